// ----- sv/test_pattern_readback_checker_macros.svh -----
// Assertion macros shared by the read-back checker modules.
`ifndef TEST_PATTERN_READBACK_CHECKER_MACROS_SVH
`define TEST_PATTERN_READBACK_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- sv/tprc_pkg.sv -----
// Types, constants and the fixed pattern table of the read-back checker.
`default_nettype none

package tprc_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 70;
   localparam int FIXED_TABLE_LEN       = 70;
   localparam int TABLE_IDX_W           = 8;
   localparam int QUEUE_DEPTH           = 4;
   localparam int QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W           = $clog2(QUEUE_DEPTH + 1);

   localparam logic [12:0] COUNT_MAX = 13'd8191;

   // Pattern source codes; the two remaining codes select the user pattern.
   localparam logic [1:0] MODE_TABLE = 2'd0;
   localparam logic [1:0] MODE_BLOCK = 2'd1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PATTERN_MODE   = 2'd0;
   localparam logic [1:0] CSR_USER_PATTERN   = 2'd1;
   localparam logic [1:0] CSR_COMPARE_ENABLE = 2'd2;
   localparam logic [1:0] CSR_ABORT_ON_ERROR = 2'd3;

   typedef enum logic [1:0] {
      KIND_ERROR = 2'd0,
      KIND_COUNT = 2'd1,
      KIND_DONE  = 2'd2
   } report_kind_type;

   // One classified input item: which reports it causes and their payload.
   typedef struct packed {
      logic        has_count;
      logic        has_error;
      logic        has_done;
      logic [15:0] block;
      logic [11:0] index;
      logic [15:0] expect_word;
      logic [15:0] data;
      logic [15:0] count_bad;
      logic [12:0] count_val;
      logic        abort;
   } tprc_action_type;

   localparam logic [15:0] FIXED_TABLE [FIXED_TABLE_LEN] = '{
      16'o000000, 16'o177777, 16'o125252, 16'o052525, 16'o070707, 16'o107070,
      16'o165555, 16'o133333, 16'o153333, 16'o177776, 16'o177775, 16'o177773,
      16'o177767, 16'o177757, 16'o177737, 16'o177677, 16'o177577, 16'o177377,
      16'o176777, 16'o175777, 16'o173777, 16'o167777, 16'o157777, 16'o137777,
      16'o077777, 16'o000001, 16'o000002, 16'o000004, 16'o000010, 16'o000020,
      16'o000040, 16'o000100, 16'o000200, 16'o000400, 16'o001000, 16'o002000,
      16'o004000, 16'o010000, 16'o020000, 16'o040000, 16'o100000, 16'o000003,
      16'o000007, 16'o000017, 16'o000037, 16'o000077, 16'o000177, 16'o000377,
      16'o000777, 16'o001777, 16'o003777, 16'o007777, 16'o017777, 16'o037777,
      16'o077777, 16'o177776, 16'o177774, 16'o177770, 16'o177760, 16'o177740,
      16'o177700, 16'o177600, 16'o177400, 16'o177000, 16'o176000, 16'o174000,
      16'o170000, 16'o160000, 16'o140000, 16'o100000
   };

   // Entries past the fixed table read as zero.
   function automatic logic [15:0] table_word(input logic [TABLE_IDX_W-1:0] idx);
      logic [15:0] word;
      if (int'(idx) < FIXED_TABLE_LEN) begin
         word = FIXED_TABLE[idx[6:0]];
      end else begin
         word = 16'd0;
      end
      return word;
   endfunction

endpackage

`default_nettype wire

// ----- sv/tprc_if.sv -----
// Channel interfaces of the read-back checker: words in, reports out, register writes.
`default_nettype none

interface tprc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_word;
   logic [11:0] word_index;
   logic [15:0] block_number;
   logic [15:0] pass_number;
   logic        last_word;

   modport source (output valid, data_word, word_index, block_number, pass_number,
                   last_word, input ready);
   modport sink (input valid, data_word, word_index, block_number, pass_number,
                 last_word, output ready);
endinterface

interface tprc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  report_kind;
   logic [15:0] report_block;
   logic [11:0] report_index;
   logic [15:0] expected_word;
   logic [15:0] bad_word;
   logic [12:0] repeat_count;
   logic        abort_request;
   logic        last_report;

   modport source (output valid, report_kind, report_block, report_index, expected_word,
                   bad_word, repeat_count, abort_request, last_report, input ready);
   modport sink (input valid, report_kind, report_block, report_index, expected_word,
                 bad_word, repeat_count, abort_request, last_report, output ready);
endinterface

interface tprc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/test_pattern_readback_checker.sv -----
// Top level of the test pattern read-back checker.
//
// req_ch carries one read-back word per item with its index, block, pass and
// a last-word mark. rsp_ch returns the reports: compare errors, repeat-count
// reports and one block-done report per block; last_report marks the final
// report of an input item. csr_ch writes the four registers and is always
// ready; write it only while no items are in flight.
// Throughput: one input item per cycle while the queue has room. An item that
// causes n reports (n at most 3) holds the result channel until all are sent,
// so the sustained rate is set by the single-report-per-cycle output register in
// the back part, which holds a report while the receiver stalls.
// The first report of an item passes the compare stage register, a queue entry
// and the output register, in that order.
// A four-entry queue sits between the compare front and the report back, so
// the front keeps taking words while the receiver stalls until it fills.
// Reset (synchronous) clears the run state, empties the queue and restores the
// register defaults; no clearing pass is needed.
`default_nettype none

module test_pattern_readback_checker #(
   parameter int TABLE_ENTRIES = tprc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tprc_req_if.sink   req_ch,
   tprc_rsp_if.source rsp_ch,
   tprc_csr_if.sink   csr_ch
);
   import tprc_pkg::*;

   tprc_action_type act_data, head_data;
   logic            act_valid, act_ready;
   logic            head_valid, head_ready;

   tprc_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .act_valid (act_valid),
      .act_ready (act_ready),
      .act_data  (act_data)
   );

   tprc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (act_valid),
      .push_ready (act_ready),
      .push_data  (act_data),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_data   (head_data)
   );

   tprc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head_data  (head_data),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- sv/tprc_queue.sv -----
// Short queue of classified items between the front and back parts.
`default_nettype none
`include "test_pattern_readback_checker_macros.svh"

module tprc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  tprc_pkg::tprc_action_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output tprc_pkg::tprc_action_type pop_data
);
   import tprc_pkg::*;

   tprc_action_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // An occupied queue only drains through a pop.
   `TPRC_ASSERT_NEXT(a_hold_until_pop, clock, reset, (count_ff != '0) && !pop, count_ff != '0)

endmodule

`default_nettype wire

// ----- sv/tprc_front.sv -----
// Front part: register file, pattern selection, compare and repeat-run tracking.
`default_nettype none
`include "test_pattern_readback_checker_macros.svh"

module tprc_front #(
   parameter int TABLE_ENTRIES = tprc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   tprc_req_if.sink                  req_ch,
   tprc_csr_if.sink                  csr_ch,
   output logic                      act_valid,
   input  logic                      act_ready,
   output tprc_pkg::tprc_action_type act_data
);
   import tprc_pkg::*;

   // pass / TABLE_ENTRIES by a rounded-up reciprocal; exact for 16-bit passes.
   localparam int          RECIP_SHIFT = 24;
   localparam longint      RECIP_VAL   =
      ((64'd1 << RECIP_SHIFT) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
   localparam logic [24:0] RECIP       = 25'(RECIP_VAL);
   localparam logic [8:0]  DIVISOR     = 9'(TABLE_ENTRIES);

   // Configuration registers.
   logic [1:0]  mode_ff;
   logic [15:0] user_ff;
   logic        cmp_en_ff;
   logic        abort_en_ff;

   // Stage one: quotient of the pass number and the captured item.
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_quot_ff;
   logic [15:0] s1_pass_ff;
   logic [15:0] s1_data_ff;
   logic [11:0] s1_index_ff;
   logic [15:0] s1_block_ff;
   logic        s1_last_ff;
   logic [40:0] quot_prod;
   logic        accept;

   // Run state.
   logic        error_seen_ff, error_seen_in;
   logic [12:0] run_count_ff, run_count_in;
   logic [15:0] run_bad_ff, run_bad_in;

   // Stage two.
   logic [24:0] quot_back;
   logic [16:0] rem_raw;
   logic [16:0] rem_fix;
   logic [15:0] expect_word;
   logic        mismatch, same_run, has_pre, has_error, has_end;
   logic        es_mid;
   logic [12:0] rc_mid;
   logic [15:0] rb_mid;
   logic        advance;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TABLE;
         user_ff     <= 16'd0;
         cmp_en_ff   <= 1'b0;
         abort_en_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_PATTERN_MODE:   mode_ff     <= csr_ch.data[1:0];
            CSR_USER_PATTERN:   user_ff     <= csr_ch.data;
            CSR_COMPARE_ENABLE: cmp_en_ff   <= csr_ch.data[0];
            CSR_ABORT_ON_ERROR: abort_en_ff <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   assign quot_prod    = 41'(req_ch.pass_number) * 41'(RECIP);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_quot_ff  <= quot_prod[RECIP_SHIFT+15:RECIP_SHIFT];
         s1_pass_ff  <= req_ch.pass_number;
         s1_data_ff  <= req_ch.data_word;
         s1_index_ff <= req_ch.word_index;
         s1_block_ff <= req_ch.block_number;
         s1_last_ff  <= req_ch.last_word;
      end
   end

   // Remainder and expected pattern.
   always_comb begin
      quot_back = 25'(s1_quot_ff) * 25'(DIVISOR);
      rem_raw   = 17'(s1_pass_ff) - quot_back[16:0];
      rem_fix   = (rem_raw >= 17'(DIVISOR)) ? rem_raw - 17'(DIVISOR) : rem_raw;
      case (mode_ff)
         MODE_TABLE: expect_word = table_word(rem_fix[TABLE_IDX_W-1:0]);
         MODE_BLOCK: expect_word = s1_block_ff;
         default:    expect_word = user_ff;
      endcase
   end

   // Compare and run tracking.
   always_comb begin
      mismatch  = cmp_en_ff && (s1_data_ff != expect_word);
      same_run  = error_seen_ff && (s1_data_ff == run_bad_ff);
      has_error = mismatch && !same_run;
      has_pre   = has_error && (run_count_ff > 13'd1);

      es_mid = has_error ? 1'b1 : error_seen_ff;
      rb_mid = has_error ? s1_data_ff : run_bad_ff;
      rc_mid = run_count_ff;
      if (has_error) begin
         rc_mid = 13'd1;
      end else if (mismatch && run_count_ff != COUNT_MAX) begin
         rc_mid = run_count_ff + 13'd1;
      end

      has_end = s1_last_ff && (rc_mid > 13'd1);

      if (s1_last_ff) begin
         error_seen_in = 1'b0;
         run_count_in  = 13'd1;
         run_bad_in    = 16'd0;
      end else begin
         error_seen_in = es_mid;
         run_count_in  = rc_mid;
         run_bad_in    = rb_mid;
      end

      act_data.has_count   = has_pre || has_end;
      act_data.has_error   = has_error;
      act_data.has_done    = s1_last_ff;
      act_data.block       = s1_block_ff;
      act_data.index       = s1_index_ff;
      act_data.expect_word = expect_word;
      act_data.data        = s1_data_ff;
      act_data.count_bad   = has_pre ? run_bad_ff : rb_mid;
      act_data.count_val   = has_pre ? run_count_ff : rc_mid;
      act_data.abort       = es_mid && abort_en_ff;
   end

   // Items that cause no report retire without a queue slot.
   assign act_valid = s1_valid_ff &&
                      (act_data.has_count || act_data.has_error || act_data.has_done);
   assign advance   = s1_valid_ff && (!act_valid || act_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         error_seen_ff <= 1'b0;
         run_count_ff  <= 13'd1;
         run_bad_ff    <= 16'd0;
      end else if (advance) begin
         error_seen_ff <= error_seen_in;
         run_count_ff  <= run_count_in;
         run_bad_ff    <= run_bad_in;
      end
   end

   // A run longer than one only exists after an error in the block.
   `TPRC_ASSERT_SAME(a_run_needs_error, clock, reset, run_count_ff > 13'd1, error_seen_ff)
   // The end of a block restores the idle run state.
   `TPRC_ASSERT_NEXT(a_block_end_clears, clock, reset, advance && s1_last_ff,
                     !error_seen_ff && (run_count_ff == 13'd1))

endmodule

`default_nettype wire

// ----- sv/tprc_back.sv -----
// Back part: turns each queued item into its reports, one per cycle while the receiver is ready.
`default_nettype none
`include "test_pattern_readback_checker_macros.svh"

module tprc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   output logic                      head_ready,
   input  tprc_pkg::tprc_action_type head_data,
   tprc_rsp_if.source                rsp_ch
);
   import tprc_pkg::*;

   // Bit 0 count report, bit 1 error, bit 2 block done; sent in that order.
   logic [2:0]      sent_ff, sent_in;
   logic [2:0]      pending, pick, rest;
   logic            slot_free, fire, is_last;
   logic            out_valid_ff, out_valid_in;
   report_kind_type kind_ff, kind_in;
   logic [15:0]     block_ff;
   logic [11:0]     index_ff;
   logic [15:0]     expect_ff;
   logic [15:0]     bad_ff, bad_in;
   logic [12:0]     count_ff, count_in;
   logic            abort_ff, abort_in;
   logic            last_ff;

   always_comb begin
      pending   = {head_data.has_done, head_data.has_error, head_data.has_count} & ~sent_ff;
      slot_free = !out_valid_ff || rsp_ch.ready;
      fire      = head_valid && slot_free;
      if (pending[0]) begin
         pick = 3'b001;
      end else if (pending[1]) begin
         pick = 3'b010;
      end else begin
         pick = 3'b100;
      end
      rest       = pending & ~pick;
      is_last    = (rest == 3'b000);
      head_ready = fire && is_last;

      sent_in = sent_ff;
      if (fire) begin
         sent_in = is_last ? 3'b000 : (sent_ff | pick);
      end
      out_valid_in = fire ? 1'b1 : (out_valid_ff && !rsp_ch.ready);
   end

   always_comb begin
      case (pick)
         3'b001: begin
            kind_in  = KIND_COUNT;
            bad_in   = head_data.count_bad;
            count_in = head_data.count_val;
            abort_in = 1'b0;
         end
         3'b010: begin
            kind_in  = KIND_ERROR;
            bad_in   = head_data.data;
            count_in = 13'd1;
            abort_in = 1'b0;
         end
         default: begin
            kind_in  = KIND_DONE;
            bad_in   = 16'd0;
            count_in = 13'd0;
            abort_in = head_data.abort;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= 3'b000;
         out_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff   <= kind_in;
         block_ff  <= head_data.block;
         index_ff  <= head_data.index;
         expect_ff <= head_data.expect_word;
         bad_ff    <= bad_in;
         count_ff  <= count_in;
         abort_ff  <= abort_in;
         last_ff   <= is_last;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.report_kind   = kind_ff;
   assign rsp_ch.report_block  = block_ff;
   assign rsp_ch.report_index  = index_ff;
   assign rsp_ch.expected_word = expect_ff;
   assign rsp_ch.bad_word      = bad_ff;
   assign rsp_ch.repeat_count  = count_ff;
   assign rsp_ch.abort_request = abort_ff;
   assign rsp_ch.last_report   = last_ff;

   // A block-done report always closes its item.
   `TPRC_ASSERT_SAME(a_done_is_last, clock, reset, fire && (pick == 3'b100), is_last)

endmodule

`default_nettype wire
